/* rtl/button_press_classifier_unit_assert.svh */
// ----------------------------------------------------------------------------
// Button press classifier assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// Button press classifier package
// Phase and event codes, register indexes, reset values and config struct.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int NOW_W         = 32;
    localparam int MS_W          = 16;
    localparam int EN_W          = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [MS_W-1:0] DEBOUNCE_MS_RST = 16'd20;
    localparam logic [MS_W-1:0] SHORT_MS_RST    = 16'd50;
    localparam logic [MS_W-1:0] LONG_MS_RST     = 16'd1000;
    localparam logic [EN_W-1:0] EVENT_EN_RST    = 3'b111;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DEBOUNCE,
        PH_HELD,
        PH_WAIT_RELEASE
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE,
        EV_PRESSED,
        EV_SHORT,
        EV_LONG
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_HIGH,
        CFG_DEBOUNCE_MS,
        CFG_SHORT_PRESS_MS,
        CFG_LONG_PRESS_MS,
        CFG_EVENT_ENABLE
    } t_cfg_idx;

    typedef enum int {
        EN_BIT_PRESSED = 0,
        EN_BIT_SHORT   = 1,
        EN_BIT_LONG    = 2
    } t_en_bit;

    typedef struct packed {
        logic            active_high;
        logic [MS_W-1:0] debounce_ms;
        logic [MS_W-1:0] short_press_ms;
        logic [MS_W-1:0] long_press_ms;
        logic [EN_W-1:0] event_enable;
    } t_cfg;

endpackage

`default_nettype wire

/* rtl/bpc_if.sv */
// ----------------------------------------------------------------------------
// Button press classifier channel interfaces
// Valid/ready channels for poll samples and classified results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpc_in_if import bpc_pkg::*;;
    logic             valid;
    logic             ready;
    logic             pin_level;
    logic [NOW_W-1:0] now_ms;

    modport source (output valid, pin_level, now_ms, input ready);
    modport sink   (input valid, pin_level, now_ms, output ready);
endinterface

interface bpc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [1:0] phase;

    modport source (output valid, event_res, phase, input ready);
    modport sink   (input valid, event_res, phase, output ready);
endinterface

`default_nettype wire

/* rtl/bpc_core.sv */
// ----------------------------------------------------------------------------
// Button press classifier core
// Press phase machine: updates its state on each step and gives the event.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_press_classifier_unit_assert.svh"

module bpc_core import bpc_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic             i_lvl,
    input  wire logic [NOW_W-1:0] i_now,
    input  wire t_cfg             i_cfg,
    output t_event                o_event,
    output t_phase                o_phase
);

    t_phase               r_phase, n_phase;
    logic                 r_last_level, n_last_level;
    logic [TIME_BITS-1:0] r_debounce_start, n_debounce_start;
    logic [TIME_BITS-1:0] r_press_time, n_press_time;

    logic                 lvl;
    logic                 pressed_edge;
    logic                 released_edge;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] el_debounce;
    logic [TIME_BITS-1:0] el_press;
    t_event               ev;

    assign lvl           = i_lvl ^ i_cfg.active_high;
    assign pressed_edge  = !lvl && r_last_level;
    assign released_edge = lvl && !r_last_level;
    assign now_t         = TIME_BITS'(i_now);
    assign el_debounce   = now_t - r_debounce_start;
    assign el_press      = now_t - r_press_time;

    always_comb begin
        n_phase          = r_phase;
        n_last_level     = r_last_level;
        n_debounce_start = r_debounce_start;
        n_press_time     = r_press_time;
        ev               = EV_NONE;
        case (r_phase)
            PH_IDLE: begin
                if (pressed_edge) begin
                    n_debounce_start = now_t;
                    n_phase          = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE: begin
                if (el_debounce > TIME_BITS'(i_cfg.debounce_ms)) begin
                    if (pressed_edge) begin
                        if (i_cfg.event_enable[EN_BIT_PRESSED]) begin
                            ev = EV_PRESSED;
                        end
                        n_press_time = now_t;
                        n_phase      = PH_HELD;
                        n_last_level = 1'b0;
                    end else if (released_edge) begin
                        n_press_time = el_press;
                        if ((el_press >= TIME_BITS'(i_cfg.short_press_ms))
                                && i_cfg.event_enable[EN_BIT_SHORT]) begin
                            ev = EV_SHORT;
                        end
                        n_last_level = 1'b1;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_last_level = 1'b1;
                        n_phase      = PH_IDLE;
                    end
                end
            end
            PH_HELD: begin
                if (released_edge) begin
                    n_phase = PH_DEBOUNCE;
                end else if (el_press > TIME_BITS'(i_cfg.long_press_ms)) begin
                    if (i_cfg.event_enable[EN_BIT_LONG]) begin
                        ev = EV_LONG;
                    end
                    n_last_level = 1'b0;
                    n_phase      = PH_WAIT_RELEASE;
                end
            end
            PH_WAIT_RELEASE: begin
                if (released_edge) begin
                    n_phase          = PH_IDLE;
                    n_last_level     = 1'b1;
                    n_debounce_start = now_t;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_last_level     <= 1'b1;
            r_debounce_start <= '0;
            r_press_time     <= '0;
        end else if (i_step) begin
            r_phase          <= n_phase;
            r_last_level     <= n_last_level;
            r_debounce_start <= n_debounce_start;
            r_press_time     <= n_press_time;
        end
    end

    assign o_event = ev;
    assign o_phase = n_phase;

    `BPC_ASSERT_SAME(a_pressed_goes_held, i_step && (ev == EV_PRESSED),
                     n_phase == PH_HELD, "pressed event without entering held")
    `BPC_ASSERT_NEXT(a_long_goes_wait, i_step && (ev == EV_LONG),
                     r_phase == PH_WAIT_RELEASE && !r_last_level,
                     "long event without entering wait release")
    `BPC_ASSERT_SAME(a_held_level_low, r_phase == PH_HELD || r_phase == PH_WAIT_RELEASE,
                     !r_last_level, "held phase with released level")

endmodule

`default_nettype wire

/* rtl/button_press_classifier_unit.sv */
// ----------------------------------------------------------------------------
// Button press classifier unit
// Debounced press, short press and long press detector for one button.
//
// Channel  Modport  Payload                     Role
// i_in     sink     pin_level, now_ms           one poll sample
// o_out    source   event_res, phase            event and phase after poll
//
// One poll is accepted per cycle unless the result stalls; each gives one result.
// The poll register feeds the phase machine, whose result is registered.
// Reset is synchronous and active low and loads the register defaults.
// A stalled result holds the pipeline; an empty poll register still fills.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_classifier_unit import bpc_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    bpc_in_if.sink                     i_in,
    bpc_out_if.source                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg             r_cfg;
    logic             r_s1_valid;
    logic             r_s1_lvl;
    logic [NOW_W-1:0] r_s1_now;
    logic             r_out_valid;
    t_event           r_out_event;
    t_phase           r_out_phase;

    logic             s1_adv;
    logic             in_take;
    t_event           core_event;
    t_phase           core_phase;

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_high    <= 1'b0;
            r_cfg.debounce_ms    <= DEBOUNCE_MS_RST;
            r_cfg.short_press_ms <= SHORT_MS_RST;
            r_cfg.long_press_ms  <= LONG_MS_RST;
            r_cfg.event_enable   <= EVENT_EN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACTIVE_HIGH:    r_cfg.active_high    <= i_cfg_wdata[0];
                CFG_DEBOUNCE_MS:    r_cfg.debounce_ms    <= i_cfg_wdata[MS_W-1:0];
                CFG_SHORT_PRESS_MS: r_cfg.short_press_ms <= i_cfg_wdata[MS_W-1:0];
                CFG_LONG_PRESS_MS:  r_cfg.long_press_ms  <= i_cfg_wdata[MS_W-1:0];
                CFG_EVENT_ENABLE:   r_cfg.event_enable   <= i_cfg_wdata[EN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (in_take) begin
            r_s1_lvl <= i_in.pin_level;
            r_s1_now <= i_in.now_ms;
        end
    end

    bpc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_adv),
        .i_lvl   (r_s1_lvl),
        .i_now   (r_s1_now),
        .i_cfg   (r_cfg),
        .o_event (core_event),
        .o_phase (core_phase)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_adv) begin
            r_out_event <= core_event;
            r_out_phase <= core_phase;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.event_res = r_out_event;
    assign o_out.phase     = r_out_phase;

endmodule

`default_nettype wire
